// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the stroke font vertex generator.
// No dependencies; each macro compiles to nothing when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapping implication checked at every clock edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/sfvg_pkg.sv =====
// Types and constants of the stroke font vertex generator.
// No dependencies; used by the channel interfaces and the top level.
package sfvg_pkg;

  localparam int GLYPH_ENTRIES = 96;
  localparam int GLYPH_AW      = 7;
  localparam int START_W       = 13;
  localparam int WORD_W        = 31;
  localparam int VTX_W         = 24;
  localparam int ADV_W         = 12;
  localparam int DELTA_W       = 14;

  localparam logic [15:0] CODE_FIRST = 16'd32;
  localparam logic [15:0] CODE_LAST  = 16'd126;
  localparam logic [15:0] CODE_DOT   = 16'd46;
  localparam logic [6:0]  PEN_UP_OP  = 7'd5;

  localparam logic [ADV_W-1:0] ADV_X_RST = 12'd92;
  localparam logic [ADV_W-1:0] ADV_Y_RST = 12'd153;

  typedef enum logic [1:0] {
    CMD_LOAD_GLYPH  = 2'd0,
    CMD_LOAD_STROKE = 2'd1,
    CMD_DRAW        = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_PATH_DIR = 2'd0,
    CFG_ADV_X    = 2'd1,
    CFG_ADV_Y    = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_START,
    S_RD_END,
    S_CALC,
    S_MOD,
    S_FETCH,
    S_ACC_Y,
    S_ACC_X,
    S_ADV
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [11:0]       table_address;
    logic [WORD_W-1:0] table_data;
    logic [15:0]       char_code;
    logic              new_segment;
  } cmd_word_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] vertex_x;
    logic signed [VTX_W-1:0] vertex_y;
    logic                    new_strip;
    logic                    truncated;
    logic                    last;
  } vtx_word_t;

endpackage

// ===== hw/rtl/sfvg_if.sv =====
// Valid/ready channels of the stroke font vertex generator.
// Depends on sfvg_pkg for the command and vertex word types.
interface sfvg_cmd_if import sfvg_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfvg_vtx_if import sfvg_pkg::*; ();
  logic      valid;
  logic      ready;
  vtx_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/stroke_font_vertex_generator.sv =====
// Stroke font vertex generator: glyph table, stroke memory, pen sequencer.
// Depends on sfvg_pkg, sfvg_if.sv and assert_macros.svh.
//
//   channel  dir  word        handshake
//   cmd_i    in   cmd_word_t  valid/ready
//   vtx_o    out  vtx_word_t  valid/ready, one output register
//   cfg      in   index/data  cfg_we_i, no read-back
//
// A load writes its table entry when accepted. A draw makes two glyph table
// reads, reduces the start address modulo STROKE_WORDS, then per word does one
// stroke read and two passes through the single saturating adder, then the
// origin advance; an empty glyph goes from the table reads to the advance.
// Reset sets the configuration to its defaults and clears origin, pen and the output valid flag.
// A full output register stalls the stroke fetch; cmd_i is ready only when idle.
`include "assert_macros.svh"

module stroke_font_vertex_generator import sfvg_pkg::*; #(
  parameter int STROKE_WORDS = 4096,
  parameter int COORD_BITS   = 24,
  parameter int MAX_VERTICES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [ADV_W-1:0]    cfg_data_i,
  sfvg_cmd_if.sink            cmd_i,
  sfvg_vtx_if.source          vtx_o
);

  localparam int AW = $clog2(STROKE_WORDS);
  localparam int UW = $clog2(MAX_VERTICES + 1);

  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  state_e state_q, state_d;
  dir_e   path_dir_q;
  logic [ADV_W-1:0] adv_x_q, adv_y_q;
  logic signed [COORD_BITS-1:0] origin_x_q, origin_x_d, origin_y_q, origin_y_d;
  logic signed [COORD_BITS-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic out_valid_q, out_valid_d;
  vtx_word_t out_q, out_d;

  logic [GLYPH_AW-1:0] g_q, g_d;
  logic [START_W-1:0]  start_q, start_d, rem_q, rem_d;
  logic [UW-1:0]       used_q, used_d, k_q, k_d;
  logic                cut_q, cut_d, sat_y_q, sat_y_d;
  logic [AW-1:0]       addr_q, addr_d;

  logic [START_W-1:0]  glyph_mem [GLYPH_ENTRIES];
  logic [START_W-1:0]  gt_rd_q;
  logic [WORD_W-1:0]   stroke_mem [STROKE_WORDS];
  logic [WORD_W-1:0]   st_rd_q;

  logic cmd_acc, out_free, is_last, x_axis;
  logic [START_W-1:0] count;
  logic [GLYPH_AW-1:0] gt_addr;

  logic signed [COORD_BITS-1:0] add_a, add_res;
  logic signed [DELTA_W-1:0]    add_b;
  logic signed [COORD_BITS:0]   add_sum;
  logic                         add_sat;

  function automatic logic signed [DELTA_W-1:0] sm12(input logic [11:0] v);
    logic signed [DELTA_W-1:0] mag;
    mag = DELTA_W'({1'b0, v[10:0]});
    return v[11] ? -mag : mag;
  endfunction

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign vtx_o.valid = out_valid_q;
  assign vtx_o.data  = out_q;
  assign out_free    = !out_valid_q || vtx_o.ready;
  assign is_last     = (UW'(k_q + UW'(1)) == used_q);
  assign x_axis      = (path_dir_q == DIR_RIGHT) || (path_dir_q == DIR_LEFT);
  assign count       = (gt_rd_q > start_q) ? START_W'(gt_rd_q - start_q) : '0;
  assign gt_addr     = (state_q == S_RD_END) ? GLYPH_AW'(g_q + GLYPH_AW'(1)) : g_q;

  // shared saturating adder
  always_comb begin
    add_a = pen_y_q;
    add_b = '0;
    case (state_q)
      S_ACC_Y: begin
        add_a = pen_y_q;
        add_b = sm12(st_rd_q[11:0]);
      end
      S_ACC_X: begin
        add_a = pen_x_q;
        add_b = sm12(st_rd_q[23:12]);
      end
      S_ADV: begin
        case (path_dir_q)
          DIR_LEFT: begin
            add_a = origin_x_q;
            add_b = -DELTA_W'({2'b0, adv_x_q});
          end
          DIR_UP: begin
            add_a = origin_y_q;
            add_b = DELTA_W'({2'b0, adv_y_q});
          end
          DIR_DOWN: begin
            add_a = origin_y_q;
            add_b = -DELTA_W'({2'b0, adv_y_q});
          end
          default: begin
            add_a = origin_x_q;
            add_b = DELTA_W'({2'b0, adv_x_q});
          end
        endcase
      end
      default: begin
        add_a = pen_y_q;
        add_b = '0;
      end
    endcase
    add_sum = (COORD_BITS+1)'(add_a) + (COORD_BITS+1)'(add_b);
    add_sat = add_sum[COORD_BITS] != add_sum[COORD_BITS-1];
    add_res = add_sat ? (add_sum[COORD_BITS] ? C_MIN : C_MAX) : add_sum[COORD_BITS-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (cmd_acc && cmd_i.data.command == CMD_DRAW) state_d = S_RD_START;
      S_RD_START: state_d = S_RD_END;
      S_RD_END:   state_d = S_CALC;
      S_CALC:     state_d = (count == '0) ? S_ADV : S_MOD;
      S_MOD:      if (int'(rem_q) < STROKE_WORDS) state_d = S_FETCH;
      S_FETCH:    if (out_free) state_d = S_ACC_Y;
      S_ACC_Y:    state_d = S_ACC_X;
      S_ACC_X:    state_d = is_last ? S_ADV : S_FETCH;
      S_ADV:      state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    origin_x_d  = origin_x_q;
    origin_y_d  = origin_y_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    out_valid_d = vtx_o.ready ? 1'b0 : out_valid_q;
    out_d       = out_q;
    g_d         = g_q;
    start_d     = start_q;
    rem_d       = rem_q;
    used_d      = used_q;
    cut_d       = cut_q;
    k_d         = k_q;
    sat_y_d     = sat_y_q;
    addr_d      = addr_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_acc && cmd_i.data.command == CMD_DRAW) begin
          if (cmd_i.data.new_segment) begin
            origin_x_d = '0;
            origin_y_d = '0;
            pen_x_d    = '0;
            pen_y_d    = '0;
          end
          if (cmd_i.data.char_code >= CODE_FIRST && cmd_i.data.char_code <= CODE_LAST) begin
            g_d = GLYPH_AW'(cmd_i.data.char_code - CODE_FIRST);
          end else begin
            g_d = GLYPH_AW'(CODE_DOT - CODE_FIRST);
          end
        end
      end
      S_RD_END: start_d = gt_rd_q;
      S_CALC: begin
        used_d = (int'(count) > MAX_VERTICES) ? UW'(MAX_VERTICES) : UW'(count);
        cut_d  = int'(count) > MAX_VERTICES;
        rem_d  = start_q;
        k_d    = '0;
      end
      S_MOD: begin
        if (int'(rem_q) >= STROKE_WORDS) begin
          rem_d = START_W'(int'(rem_q) - STROKE_WORDS);
        end else begin
          addr_d = (rem_q == '0) ? AW'(STROKE_WORDS - 1) : AW'(rem_q - START_W'(1));
        end
      end
      S_ACC_Y: begin
        pen_y_d = add_res;
        sat_y_d = add_sat;
      end
      S_ACC_X: begin
        pen_x_d           = add_res;
        out_valid_d       = 1'b1;
        out_d.vertex_x    = VTX_W'(add_res);
        out_d.vertex_y    = VTX_W'(pen_y_q);
        out_d.new_strip   = (k_q == '0) || (st_rd_q[30:24] == PEN_UP_OP);
        out_d.truncated   = sat_y_q || add_sat || (is_last && cut_q);
        out_d.last        = is_last;
        k_d               = UW'(k_q + UW'(1));
        addr_d            = (addr_q == AW'(STROKE_WORDS - 1)) ? '0 : AW'(addr_q + AW'(1));
      end
      S_ADV: begin
        if (x_axis) begin
          origin_x_d = add_res;
          pen_x_d    = add_res;
          pen_y_d    = origin_y_q;
        end else begin
          origin_y_d = add_res;
          pen_y_d    = add_res;
          pen_x_d    = origin_x_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      path_dir_q  <= DIR_RIGHT;
      adv_x_q     <= ADV_X_RST;
      adv_y_q     <= ADV_Y_RST;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      origin_x_q  <= origin_x_d;
      origin_y_q  <= origin_y_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PATH_DIR: path_dir_q <= dir_e'(cfg_data_i[1:0]);
          CFG_ADV_X:    adv_x_q    <= cfg_data_i;
          CFG_ADV_Y:    adv_y_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    g_q     <= g_d;
    start_q <= start_d;
    rem_q   <= rem_d;
    used_q  <= used_d;
    cut_q   <= cut_d;
    k_q     <= k_d;
    sat_y_q <= sat_y_d;
    addr_q  <= addr_d;
  end

  // glyph start table
  always_ff @(posedge clk_i) begin
    if (cmd_acc && cmd_i.data.command == CMD_LOAD_GLYPH &&
        int'(cmd_i.data.table_address) < GLYPH_ENTRIES) begin
      glyph_mem[GLYPH_AW'(cmd_i.data.table_address)] <= cmd_i.data.table_data[START_W-1:0];
    end
    if (state_q == S_RD_START || state_q == S_RD_END) begin
      gt_rd_q <= glyph_mem[gt_addr];
    end
  end

  // stroke word memory
  always_ff @(posedge clk_i) begin
    if (cmd_acc && cmd_i.data.command == CMD_LOAD_STROKE &&
        int'(cmd_i.data.table_address) < STROKE_WORDS) begin
      stroke_mem[AW'(cmd_i.data.table_address)] <= cmd_i.data.table_data;
    end
    if (state_q == S_FETCH && out_free) begin
      st_rd_q <= stroke_mem[addr_q];
    end
  end

  `ASSERT_IMPLIES(a_walk_in_bound, clk_i, rst_ni,
    state_q == S_FETCH || state_q == S_ACC_Y || state_q == S_ACC_X,
    k_q < used_q && used_q <= UW'(MAX_VERTICES), "vertex index outside glyph bound")
  `ASSERT_IMPLIES(a_slot_free, clk_i, rst_ni, state_q == S_ACC_X, !out_valid_q,
    "vertex produced while output register still full")
  `ASSERT_ALWAYS(a_pen_home, clk_i, rst_ni,
    $past(state_q) == S_ADV |-> pen_x_q == origin_x_q && pen_y_q == origin_y_q,
    "pen not returned to origin after advance")

endmodule
